// ===== sv/jms_pkg.sv =====
package jms_pkg;

   // lexical modes of the minifier
   typedef enum logic [3:0] {
      LEX_NEXT,
      LEX_LINE,
      LEX_BLOCK,
      LEX_BSTAR,
      LEX_STR,
      LEX_STRESC,
      LEX_RE,
      LEX_REESC,
      LEX_DONE
   } lex_mode_type;

   // error codes carried on the final marker
   typedef enum logic [1:0] {
      ERR_NONE,
      ERR_COMMENT,
      ERR_STRING,
      ERR_REGEX
   } error_type;

   // most bytes one source byte can release
   localparam int MaxChars       = 3;
   localparam int CharCountWidth = $clog2(MaxChars + 1);

   // character constants
   localparam logic [7:0] CH_LF        = 8'h0A;
   localparam logic [7:0] CH_CR        = 8'h0D;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_SLASH     = 8'h2F;
   localparam logic [7:0] CH_STAR      = 8'h2A;
   localparam logic [7:0] CH_BSLASH    = 8'h5C;
   localparam logic [7:0] CH_DQUOTE    = 8'h22;
   localparam logic [7:0] CH_SQUOTE    = 8'h27;
   localparam logic [7:0] CH_DOLLAR    = 8'h24;
   localparam logic [7:0] CH_USCORE    = 8'h5F;
   localparam logic [7:0] CH_IDENT_MAX = 8'd126;

   // one accepted source item
   typedef struct packed {
      logic [7:0] in_char;
      logic       end_of_input;
   } item_type;

   // all results released by one item
   typedef struct packed {
      logic [MaxChars-1:0][7:0]  chars;
      logic [CharCountWidth-1:0] count;
      logic                      ending;
      error_type                 err;
   } bundle_type;

   // lexer state plus the bytes released so far in this step
   typedef struct packed {
      lex_mode_type              mode;
      logic [7:0]                held_a;
      logic [7:0]                quote;
      logic                      keep_live;
      logic                      pending_slash;
      logic                      after_regex;
      error_type                 err;
      logic [MaxChars-1:0][7:0]  chars;
      logic [CharCountWidth-1:0] count;
   } ctx_type;

endpackage

// ===== sv/jms_req_if.sv =====
interface jms_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_char;
   logic       end_of_input;

   modport source (output valid, output in_char, output end_of_input, input ready);
   modport sink (input valid, input in_char, input end_of_input, output ready);
endinterface

// ===== sv/jms_rsp_if.sv =====
interface jms_rsp_if import jms_pkg::*; ;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       char_valid;
   logic       last_of_run;
   error_type  error_code;
   logic       stream_done;

   modport source (
      output valid, output out_char, output char_valid, output last_of_run,
      output error_code, output stream_done, input ready
   );
   modport sink (
      input valid, input out_char, input char_valid, input last_of_run,
      input error_code, input stream_done, output ready
   );
endinterface

// ===== sv/jms_csr_if.sv =====
interface jms_csr_if;
   logic valid;
   logic ready;
   logic keep_first_comment;

   modport source (output valid, output keep_first_comment, input ready);
   modport sink (input valid, input keep_first_comment, output ready);
endinterface

// ===== sv/jms_input_reg.sv =====
module jms_input_reg import jms_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   jms_req_if.sink  req_ch,
   input  logic     consume,
   output logic     item_valid,
   output item_type item
);

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;

   // free when empty or when the held item moves on this cycle
   assign req_ch.ready = !valid_ff || consume;

   // next value of the input register
   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (req_ch.valid && req_ch.ready) begin
         valid_in             = 1'b1;
         item_in.in_char      = req_ch.in_char;
         item_in.end_of_input = req_ch.end_of_input;
      end else if (consume) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ===== sv/jms_lexer.sv =====
module jms_lexer import jms_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  item_type   item,
   input  logic       consume,
   input  logic       csr_write,
   input  logic       csr_keep_first_comment,
   output bundle_type bundle,
   output logic       has_results
);

   // what the window does with a new significant character
   typedef enum logic [1:0] {
      ACT_EMIT_SHIFT,
      ACT_SHIFT,
      ACT_DROP
   } window_action_type;

   lex_mode_type mode_ff, mode_in;
   logic [7:0]   held_a_ff, held_a_in;
   logic [7:0]   quote_ff, quote_in;
   logic         keep_live_ff, keep_live_in;
   logic         pending_ff, pending_in;
   logic         after_regex_ff, after_regex_in;
   logic         started_ff, started_in;

   ctx_type      step;
   ctx_type      start;
   logic [7:0]   c;
   logic         c_end;

   function automatic logic is_ident(logic [7:0] ch);
      return (ch >= "a" && ch <= "z") || (ch >= "0" && ch <= "9") ||
             (ch >= "A" && ch <= "Z") || ch == CH_USCORE || ch == CH_DOLLAR ||
             ch == CH_BSLASH || ch > CH_IDENT_MAX;
   endfunction

   function automatic logic is_blank(logic [7:0] ch);
      return ch == CH_SPACE || ch == CH_TAB || ch == CH_CR || ch == CH_LF;
   endfunction

   function automatic logic regex_opener(logic [7:0] ch);
      return ch == "(" || ch == "," || ch == "=" || ch == ":" || ch == "[" ||
             ch == "!" || ch == "&" || ch == "|" || ch == "?" || ch == "{" ||
             ch == "}" || ch == ";" || ch == CH_LF;
   endfunction

   function automatic logic [7:0] translate(logic [7:0] ch, logic keep);
      logic [7:0] r;
      if (ch >= CH_SPACE || ch == CH_LF) begin
         r = ch;
      end else if (ch == CH_CR) begin
         r = keep ? CH_CR : CH_LF;
      end else begin
         r = CH_SPACE;
      end
      return r;
   endfunction

   // append one byte to the step's output
   function automatic ctx_type emit(ctx_type x_in, logic [7:0] ch);
      ctx_type x;
      x = x_in;
      if (x.count < CharCountWidth'(MaxChars)) begin
         x.chars[x.count] = ch;
         x.count          = x.count + 1'b1;
      end
      return x;
   endfunction

   function automatic ctx_type fail(ctx_type x_in, error_type code);
      ctx_type x;
      x      = x_in;
      x.err  = code;
      x.mode = LEX_DONE;
      return x;
   endfunction

   // a new significant character reaches the window
   function automatic ctx_type take_b(ctx_type x_in, logic [7:0] b, logic b_end);
      ctx_type           x;
      logic [7:0]        a;
      logic              check_re;
      window_action_type act;
      x             = x_in;
      a             = x.held_a;
      check_re      = !x.after_regex;
      x.after_regex = 1'b0;
      act           = ACT_EMIT_SHIFT;
      if (check_re && !b_end && b == CH_SLASH && regex_opener(a)) begin
         x      = emit(x, a);
         x      = emit(x, CH_SLASH);
         x.mode = LEX_RE;
      end else if (b_end) begin
         if (a != CH_SPACE && a != CH_LF) begin
            x = emit(x, a);
         end
         x.mode = LEX_DONE;
      end else begin
         if (a == CH_SPACE) begin
            act = is_ident(b) ? ACT_EMIT_SHIFT : ACT_SHIFT;
         end else if (a == CH_LF) begin
            if (b == "{" || b == "[" || b == "(" || b == "+" || b == "-") begin
               act = ACT_EMIT_SHIFT;
            end else if (b == CH_SPACE) begin
               act = ACT_DROP;
            end else begin
               act = is_ident(b) ? ACT_EMIT_SHIFT : ACT_SHIFT;
            end
         end else if (b == CH_SPACE) begin
            act = is_ident(a) ? ACT_EMIT_SHIFT : ACT_DROP;
         end else if (b == CH_LF) begin
            if (a == "}" || a == "]" || a == ")" || a == "+" || a == "-" ||
                a == CH_DQUOTE || a == CH_SQUOTE) begin
               act = ACT_EMIT_SHIFT;
            end else begin
               act = is_ident(a) ? ACT_EMIT_SHIFT : ACT_DROP;
            end
         end
         if (act == ACT_EMIT_SHIFT) begin
            x = emit(x, a);
         end
         if (act != ACT_DROP) begin
            x.held_a = b;
         end
         if (act != ACT_DROP && (b == CH_SQUOTE || b == CH_DQUOTE)) begin
            x       = emit(x, b);
            x.quote = b;
            x.mode  = LEX_STR;
         end else begin
            x.mode = LEX_NEXT;
         end
      end
      return x;
   endfunction

   // normal mode with no slash pending
   function automatic ctx_type feed_next(ctx_type x_in, logic [7:0] ch, logic ch_end);
      ctx_type x;
      x = x_in;
      if (x.keep_live && (ch_end || (ch != CH_SLASH && !is_blank(ch)))) begin
         x.keep_live = 1'b0;
      end
      if (!ch_end && ch == CH_SLASH) begin
         x.pending_slash = 1'b1;
      end else begin
         x = take_b(x, ch, ch_end);
      end
      return x;
   endfunction

   function automatic ctx_type feed_block(ctx_type x_in, logic [7:0] ch, logic ch_end);
      ctx_type x;
      x = x_in;
      if (!ch_end && ch == CH_STAR) begin
         x.mode = LEX_BSTAR;
      end else if (ch_end) begin
         x = fail(x, ERR_COMMENT);
      end else if (x.keep_live && ch != CH_CR) begin
         x = emit(x, ch);
      end
      return x;
   endfunction

   function automatic ctx_type feed_re(ctx_type x_in, logic [7:0] ch, logic ch_end);
      ctx_type x;
      x = x_in;
      if (!ch_end && ch == CH_SLASH) begin
         x.held_a      = CH_SLASH;
         x.after_regex = 1'b1;
         x.mode        = LEX_NEXT;
      end else if (!ch_end && ch == CH_BSLASH) begin
         x      = emit(x, CH_BSLASH);
         x.mode = LEX_REESC;
      end else if (ch_end) begin
         x = fail(x, ERR_REGEX);
      end else begin
         x = emit(x, ch);
      end
      return x;
   endfunction

   // current state as the starting point of one step
   always_comb begin
      start               = '0;
      start.mode          = mode_ff;
      start.held_a        = held_a_ff;
      start.quote         = quote_ff;
      start.keep_live     = keep_live_ff;
      start.pending_slash = pending_ff;
      start.after_regex   = after_regex_ff;
      start.err           = ERR_NONE;
      c                   = translate(item.in_char, keep_live_ff);
      c_end               = item.end_of_input;
   end

   // one item through the lexer
   always_comb begin
      step = start;
      case (start.mode)
         LEX_NEXT: begin
            if (!start.pending_slash) begin
               step = feed_next(step, c, c_end);
            end else begin
               step.pending_slash = 1'b0;
               if (!c_end && c == CH_SLASH) begin
                  step.keep_live = 1'b0;
                  step.mode      = LEX_LINE;
               end else if (!c_end && c == CH_STAR) begin
                  if (step.keep_live) begin
                     step = emit(step, CH_SLASH);
                     step = emit(step, CH_STAR);
                  end
                  step.mode = LEX_BLOCK;
               end else begin
                  // the slash was a plain character: push it, then re-read this byte
                  step.keep_live = 1'b0;
                  step = take_b(step, CH_SLASH, 1'b0);
                  if (step.mode == LEX_RE) begin
                     step = feed_re(step, c, c_end);
                  end else begin
                     step = feed_next(step, c, c_end);
                  end
               end
            end
         end
         LEX_LINE: begin
            if (c_end || c <= CH_LF) begin
               step = take_b(step, c, c_end);
            end
         end
         LEX_BLOCK: begin
            step = feed_block(step, c, c_end);
         end
         LEX_BSTAR: begin
            if (!c_end && c == CH_SLASH) begin
               if (step.keep_live) begin
                  step           = emit(step, CH_STAR);
                  step           = emit(step, CH_SLASH);
                  step.keep_live = 1'b0;
               end
               step = take_b(step, CH_SPACE, 1'b0);
            end else begin
               if (step.keep_live) begin
                  step = emit(step, CH_STAR);
               end
               step.mode = LEX_BLOCK;
               step      = feed_block(step, c, c_end);
            end
         end
         LEX_STR: begin
            if (!c_end && c == start.quote) begin
               step.held_a = start.quote;
               step.mode   = LEX_NEXT;
            end else if (!c_end && c == CH_BSLASH) begin
               step      = emit(step, CH_BSLASH);
               step.mode = LEX_STRESC;
            end else if (c_end) begin
               step = fail(step, ERR_STRING);
            end else begin
               step = emit(step, c);
            end
         end
         LEX_STRESC: begin
            if (c_end) begin
               step = fail(step, ERR_STRING);
            end else begin
               step      = emit(step, c);
               step.mode = LEX_STR;
            end
         end
         LEX_RE: begin
            step = feed_re(step, c, c_end);
         end
         LEX_REESC: begin
            if (c_end) begin
               step = fail(step, ERR_REGEX);
            end else begin
               step      = emit(step, c);
               step.mode = LEX_RE;
            end
         end
         default: begin
         end
      endcase
      if (c_end) begin
         step.mode = LEX_DONE;
      end
   end

   // next state
   always_comb begin
      mode_in        = mode_ff;
      held_a_in      = held_a_ff;
      quote_in       = quote_ff;
      keep_live_in   = keep_live_ff;
      pending_in     = pending_ff;
      after_regex_in = after_regex_ff;
      started_in     = started_ff;
      if (consume) begin
         mode_in        = step.mode;
         held_a_in      = step.held_a;
         quote_in       = step.quote;
         keep_live_in   = step.keep_live;
         pending_in     = step.pending_slash;
         after_regex_in = step.after_regex;
         started_in     = 1'b1;
      end else if (csr_write && !started_ff) begin
         keep_live_in = csr_keep_first_comment;
      end
   end

   // outputs of the step
   always_comb begin
      bundle.chars  = step.chars;
      bundle.count  = step.count;
      bundle.ending = c_end;
      bundle.err    = step.err;
      has_results   = (mode_ff != LEX_DONE) && ((step.count != '0) || c_end);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= LEX_NEXT;
         held_a_ff      <= CH_LF;
         quote_ff       <= 8'h00;
         keep_live_ff   <= 1'b0;
         pending_ff     <= 1'b0;
         after_regex_ff <= 1'b0;
         started_ff     <= 1'b0;
      end else begin
         mode_ff        <= mode_in;
         held_a_ff      <= held_a_in;
         quote_ff       <= quote_in;
         keep_live_ff   <= keep_live_in;
         pending_ff     <= pending_in;
         after_regex_ff <= after_regex_in;
         started_ff     <= started_in;
      end
   end

endmodule

// ===== sv/jms_result_buf.sv =====
module jms_result_buf import jms_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  bundle_type bundle,
   output logic       free,
   jms_rsp_if.source  rsp_ch
);

   logic                      valid_ff, valid_in;
   logic [CharCountWidth-1:0] idx_ff, idx_in;
   bundle_type                bundle_ff, bundle_in;

   logic [CharCountWidth:0]   total;
   logic                      is_char;
   logic                      last;

   // position within the bundle
   always_comb begin
      total   = {1'b0, bundle_ff.count} + {{CharCountWidth{1'b0}}, bundle_ff.ending};
      is_char = idx_ff < bundle_ff.count;
      last    = ({1'b0, idx_ff} == (total - 1'b1));
      free    = !valid_ff || (rsp_ch.ready && last);
   end

   // present the current result
   always_comb begin
      rsp_ch.valid       = valid_ff;
      rsp_ch.out_char    = is_char ? bundle_ff.chars[idx_ff] : 8'h00;
      rsp_ch.char_valid  = is_char;
      rsp_ch.last_of_run = last;
      rsp_ch.error_code  = is_char ? ERR_NONE : bundle_ff.err;
      rsp_ch.stream_done = !is_char;
   end

   // load a new bundle or step through the current one on each transfer
   always_comb begin
      valid_in  = valid_ff;
      idx_in    = idx_ff;
      bundle_in = bundle_ff;
      if (load) begin
         valid_in  = 1'b1;
         idx_in    = '0;
         bundle_in = bundle;
      end else if (valid_ff && rsp_ch.ready) begin
         if (last) begin
            valid_in = 1'b0;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      bundle_ff <= bundle_in;
   end

endmodule

// ===== sv/javascript_minifier_stream.sv =====
// path: a byte is held in the input register, its results in the output register
// throughput: one byte per cycle while each byte gives at most one result and the
//   output is ready; a byte with more results holds the output register until all
//   are taken; meanwhile no-result bytes pass, others wait in the input register
// reset: synchronous, active high; window back to a newline, normal mode, all
//   registers empty, keep-first-comment off; no clearing pass
module javascript_minifier_stream import jms_pkg::*; (
   input logic       clock,
   input logic       reset,
   jms_req_if.sink   req_ch,
   jms_rsp_if.source rsp_ch,
   jms_csr_if.sink   csr_ch
);

   logic       item_valid;
   item_type   item;
   bundle_type bundle;
   logic       has_results;
   logic       buf_free;
   logic       consume;
   logic       load;

   // the configuration write is always taken
   assign csr_ch.ready = 1'b1;

   // an item leaves the input register when its results have room
   assign consume = item_valid && (!has_results || buf_free);
   assign load    = consume && has_results;

   jms_input_reg u_input_reg (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .consume    (consume),
      .item_valid (item_valid),
      .item       (item)
   );

   jms_lexer u_lexer (
      .clock                  (clock),
      .reset                  (reset),
      .item                   (item),
      .consume                (consume),
      .csr_write              (csr_ch.valid && csr_ch.ready),
      .csr_keep_first_comment (csr_ch.keep_first_comment),
      .bundle                 (bundle),
      .has_results            (has_results)
   );

   jms_result_buf u_result_buf (
      .clock  (clock),
      .reset  (reset),
      .load   (load),
      .bundle (bundle),
      .free   (buf_free),
      .rsp_ch (rsp_ch)
   );

endmodule

// ===== sv/jms_checker.sv =====
module jms_checker import jms_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_char,
   input logic       rsp_char_valid,
   input logic       rsp_last_of_run,
   input error_type  rsp_error_code,
   input logic       rsp_stream_done
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_char) &&
      $stable(rsp_char_valid) && $stable(rsp_last_of_run) &&
      $stable(rsp_error_code) && $stable(rsp_stream_done))
      else $error("stalled result changed");

   // the final marker closes its run and carries no byte
   a_marker_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stream_done |->
      rsp_last_of_run && !rsp_char_valid && rsp_out_char == 8'h00)
      else $error("malformed final marker");

   // errors appear only on the final marker
   a_error_on_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_code != ERR_NONE |-> rsp_stream_done)
      else $error("error code on a byte result");

   // nothing follows the final marker
   a_quiet_after_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_stream_done |=> !rsp_valid)
      else $error("result after end of stream");

   // reset empties the output
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

endmodule

bind javascript_minifier_stream jms_checker u_jms_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_out_char    (rsp_ch.out_char),
   .rsp_char_valid  (rsp_ch.char_valid),
   .rsp_last_of_run (rsp_ch.last_of_run),
   .rsp_error_code  (rsp_ch.error_code),
   .rsp_stream_done (rsp_ch.stream_done)
);

// ===== tb/tb_top.sv =====
module tb_top import jms_pkg::*; ;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HALF_PERIOD  = 10;
   localparam int RESET_CYCLES = 6;
   localparam int MAX_GAP      = 13;
   localparam int IDLE_LIMIT   = 400;
   localparam int DRAIN_CYCLES = 8;
   localparam int RANDOM_ITEMS = 240;
   localparam int END_MARK     = -1;

   // character codes as plain integers, so the end mark compares signed
   localparam int C_LF     = CH_LF;
   localparam int C_CR     = CH_CR;
   localparam int C_TAB    = CH_TAB;
   localparam int C_SPACE  = CH_SPACE;
   localparam int C_SLASH  = CH_SLASH;
   localparam int C_STAR   = CH_STAR;
   localparam int C_BSLASH = CH_BSLASH;
   localparam int C_DQUOTE = CH_DQUOTE;
   localparam int C_SQUOTE = CH_SQUOTE;
   localparam int C_DOLLAR = CH_DOLLAR;
   localparam int C_USCORE = CH_USCORE;
   localparam int C_IDMAX  = CH_IDENT_MAX;

   localparam logic TYPED     = 1'b1;
   localparam logic PREDICTED = 1'b0;

   // what a new window character does to the held one
   typedef enum {
      WIN_EMIT,
      WIN_DROP_A,
      WIN_DROP_B
   } window_step_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       char_valid;
      logic       last_of_run;
      error_type  error_code;
      logic       stream_done;
   } min_out_type;

   typedef struct packed {
      logic [7:0]      ch;
      logic            eoi;
      logic            typed;
      logic [1:0]      n_want;
      logic [0:2][7:0] want;
   } directed_row_type;

   // opening comment kept (CR dropped, control bytes as spaces), then every lexical mode but LEX_DONE
   localparam directed_row_type DIRECTED [28] = '{
      '{"/",     1'b0, TYPED,     2'd0, '0},
      '{"*",     1'b0, TYPED,     2'd2, {CH_SLASH, CH_STAR, 8'h00}},
      '{CH_CR,   1'b0, TYPED,     2'd0, '0},
      '{8'h01,   1'b0, TYPED,     2'd1, {CH_SPACE, 8'h00, 8'h00}},
      '{8'hFF,   1'b0, TYPED,     2'd1, {8'hFF, 8'h00, 8'h00}},
      '{"*",     1'b0, TYPED,     2'd0, '0},
      '{"x",     1'b0, TYPED,     2'd2, {CH_STAR, 8'h78, 8'h00}},
      '{"*",     1'b0, PREDICTED, 2'd0, '0},
      '{"/",     1'b0, PREDICTED, 2'd0, '0},
      '{"a",     1'b0, PREDICTED, 2'd0, '0},
      '{CH_TAB,  1'b0, PREDICTED, 2'd0, '0},
      '{"$",     1'b0, PREDICTED, 2'd0, '0},
      '{CH_CR,   1'b0, PREDICTED, 2'd0, '0},
      '{"(",     1'b0, PREDICTED, 2'd0, '0},
      '{CH_SQUOTE, 1'b0, PREDICTED, 2'd0, '0},
      '{CH_BSLASH, 1'b0, PREDICTED, 2'd0, '0},
      '{CH_SQUOTE, 1'b0, PREDICTED, 2'd0, '0},
      '{CH_SQUOTE, 1'b0, PREDICTED, 2'd0, '0},
      '{"=",     1'b0, PREDICTED, 2'd0, '0},
      '{"/",     1'b0, PREDICTED, 2'd0, '0},
      '{CH_BSLASH, 1'b0, PREDICTED, 2'd0, '0},
      '{"/",     1'b0, PREDICTED, 2'd0, '0},
      '{"/",     1'b0, PREDICTED, 2'd0, '0},
      '{"/",     1'b0, PREDICTED, 2'd0, '0},
      '{"/",     1'b0, PREDICTED, 2'd0, '0},
      '{8'h00,   1'b0, PREDICTED, 2'd0, '0},
      '{CH_LF,   1'b0, PREDICTED, 2'd0, '0},
      '{8'h7F,   1'b0, PREDICTED, 2'd0, '0}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   always #HALF_PERIOD clock = ~clock;

   jms_req_if req_ch ();
   jms_rsp_if rsp_ch ();
   jms_csr_if csr_ch ();

   javascript_minifier_stream u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   min_out_type minified_q [$];
   logic [7:0]  released [$];
   logic [7:0]  source_text [$];
   bit          mismatch_seen = 1'b0;
   int          idle_cycles   = 0;
   bit          src_quiet     = 1'b0;
   int          items_sent    = 0;

   // minifier state as the testbench tracks it
   logic         keep_cfg;
   lex_mode_type lx_mode;
   logic [7:0]   win_a;
   logic [7:0]   quote_ch;
   logic         keep_live;
   logic         slash_held;
   logic         regex_just_closed;
   logic         stream_started;
   error_type    stream_err;

   function automatic bit is_ident(int c);
      return (c >= int'("a") && c <= int'("z")) || (c >= int'("0") && c <= int'("9")) ||
             (c >= int'("A") && c <= int'("Z")) || c == C_USCORE || c == C_DOLLAR ||
             c == C_BSLASH || c > C_IDMAX;
   endfunction

   function automatic bit is_blank(int c);
      return c == C_SPACE || c == C_TAB || c == C_CR || c == C_LF;
   endfunction

   function automatic bit opens_regex(int a);
      return a == "(" || a == "," || a == "=" || a == ":" || a == "[" || a == "!" ||
             a == "&" || a == "|" || a == "?" || a == "{" || a == "}" || a == ";" ||
             a == C_LF;
   endfunction

   function automatic int xlate(logic [7:0] ch);
      int c;
      c = ch;
      if (c >= C_SPACE || c == C_LF) return c;
      if (c == C_CR) return keep_live ? C_CR : C_LF;
      return C_SPACE;
   endfunction

   function automatic void release_byte(int c);
      if (released.size() < MaxChars) released.push_back(c[7:0]);
   endfunction

   function automatic void close_with(error_type code);
      stream_err = code;
      lx_mode    = LEX_DONE;
   endfunction

   // a new significant character enters the two-character window
   function automatic void take_window(int b);
      int              a;
      window_step_type step;
      bit              check_re;
      a = win_a;
      check_re = !regex_just_closed;
      regex_just_closed = 1'b0;
      if (check_re && b == C_SLASH && opens_regex(a)) begin
         release_byte(a);
         release_byte(C_SLASH);
         lx_mode = LEX_RE;
         return;
      end
      if (b < 0) begin
         if (a != C_SPACE && a != C_LF) release_byte(a);
         lx_mode = LEX_DONE;
         return;
      end
      if (a == C_SPACE) begin
         step = is_ident(b) ? WIN_EMIT : WIN_DROP_A;
      end else if (a == C_LF) begin
         if (b == "{" || b == "[" || b == "(" || b == "+" || b == "-") step = WIN_EMIT;
         else if (b == C_SPACE) step = WIN_DROP_B;
         else step = is_ident(b) ? WIN_EMIT : WIN_DROP_A;
      end else if (b == C_SPACE) begin
         step = is_ident(a) ? WIN_EMIT : WIN_DROP_B;
      end else if (b == C_LF) begin
         if (a == "}" || a == "]" || a == ")" || a == "+" || a == "-" ||
             a == C_DQUOTE || a == C_SQUOTE) step = WIN_EMIT;
         else step = is_ident(a) ? WIN_EMIT : WIN_DROP_B;
      end else begin
         step = WIN_EMIT;
      end
      if (step != WIN_DROP_B) begin
         if (step == WIN_EMIT) release_byte(a);
         win_a = b[7:0];
         if (b == C_SQUOTE || b == C_DQUOTE) begin
            release_byte(b);
            quote_ch = b[7:0];
            lx_mode  = LEX_STR;
            return;
         end
      end
      lx_mode = LEX_NEXT;
   endfunction

   // one translated character, or the end mark, through the lexer
   function automatic void lex_char(int c);
      bit again;
      again = 1'b1;
      while (again) begin
         again = 1'b0;
         case (lx_mode)
            LEX_NEXT: begin
               if (!slash_held) begin
                  if (keep_live && c != C_SLASH && !is_blank(c)) keep_live = 1'b0;
                  if (c == C_SLASH) slash_held = 1'b1;
                  else take_window(c);
               end else begin
                  slash_held = 1'b0;
                  if (c == C_SLASH) begin
                     keep_live = 1'b0;
                     lx_mode   = LEX_LINE;
                  end else if (c == C_STAR) begin
                     if (keep_live) begin
                        release_byte(C_SLASH);
                        release_byte(C_STAR);
                     end
                     lx_mode = LEX_BLOCK;
                  end else begin
                     keep_live = 1'b0;
                     take_window(C_SLASH);
                     again = 1'b1;
                  end
               end
            end
            LEX_LINE: begin
               if (c <= C_LF) take_window(c);
            end
            LEX_BLOCK: begin
               if (c == C_STAR) lx_mode = LEX_BSTAR;
               else if (c < 0) close_with(ERR_COMMENT);
               else if (keep_live && c != C_CR) release_byte(c);
            end
            LEX_BSTAR: begin
               if (c == C_SLASH) begin
                  if (keep_live) begin
                     release_byte(C_STAR);
                     release_byte(C_SLASH);
                     keep_live = 1'b0;
                  end
                  take_window(C_SPACE);
               end else begin
                  if (keep_live) release_byte(C_STAR);
                  lx_mode = LEX_BLOCK;
                  again   = 1'b1;
               end
            end
            LEX_STR: begin
               if (c == int'(quote_ch)) begin
                  win_a   = quote_ch;
                  lx_mode = LEX_NEXT;
               end else if (c == C_BSLASH) begin
                  release_byte(C_BSLASH);
                  lx_mode = LEX_STRESC;
               end else if (c < 0) begin
                  close_with(ERR_STRING);
               end else begin
                  release_byte(c);
               end
            end
            LEX_STRESC: begin
               if (c < 0) begin
                  close_with(ERR_STRING);
               end else begin
                  release_byte(c);
                  lx_mode = LEX_STR;
               end
            end
            LEX_RE: begin
               if (c == C_SLASH) begin
                  win_a             = CH_SLASH;
                  regex_just_closed = 1'b1;
                  lx_mode           = LEX_NEXT;
               end else if (c == C_BSLASH) begin
                  release_byte(C_BSLASH);
                  lx_mode = LEX_REESC;
               end else if (c < 0) begin
                  close_with(ERR_REGEX);
               end else begin
                  release_byte(c);
               end
            end
            LEX_REESC: begin
               if (c < 0) begin
                  close_with(ERR_REGEX);
               end else begin
                  release_byte(c);
                  lx_mode = LEX_RE;
               end
            end
            default: ;
         endcase
      end
   endfunction

   // bytes released by one source item; returns 1 when it closes the stream
   function automatic bit minify_item(logic [7:0] ch, logic eoi);
      released.delete();
      if (lx_mode == LEX_DONE) return 1'b0;
      stream_started = 1'b1;
      if (!eoi) begin
         lex_char(xlate(ch));
      end else begin
         for (int g = 0; g < 8 && lx_mode != LEX_DONE; g++) lex_char(END_MARK);
         lx_mode = LEX_DONE;
      end
      return eoi;
   endfunction

   function automatic void push_byte(logic [7:0] b, bit last);
      min_out_type r;
      r.out_char    = b;
      r.char_valid  = 1'b1;
      r.last_of_run = last;
      r.error_code  = ERR_NONE;
      r.stream_done = 1'b0;
      minified_q.push_back(r);
   endfunction

   function automatic void push_released(bit closes);
      min_out_type r;
      foreach (released[k]) push_byte(released[k], !closes && k == released.size() - 1);
      if (closes) begin
         r.out_char    = 8'h00;
         r.char_valid  = 1'b0;
         r.last_of_run = 1'b1;
         r.error_code  = stream_err;
         r.stream_done = 1'b1;
         minified_q.push_back(r);
      end
   endfunction

   // one source byte transfer, then its expected output
   task automatic send_item(input logic [7:0] ch, input logic eoi,
                            input logic typed = PREDICTED, input int n_want = 0,
                            input logic [0:2][7:0] want = '0);
      int gap;
      bit closes;
      gap = src_quiet ? 0 : $urandom_range(0, MAX_GAP);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.in_char      <= ch;
      req_ch.end_of_input <= eoi;
      do @(posedge clock); while (!req_ch.ready);
      closes = minify_item(ch, eoi);
      if (typed) begin
         for (int k = 0; k < n_want; k++) push_byte(want[k], k == n_want - 1);
      end else begin
         push_released(closes);
      end
      items_sent++;
      if (items_sent % 16 == 0) src_quiet = ($urandom_range(0, 3) == 0);
   endtask

   task automatic settle_block();
      while (minified_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // register write with the block idle
   task automatic write_keep(input logic v);
      req_ch.valid <= 1'b0;
      settle_block();
      csr_ch.valid              <= 1'b1;
      csr_ch.keep_first_comment <= v;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      keep_cfg = v;
      if (!stream_started) keep_live = keep_cfg;
   endtask

   function automatic logic [7:0] ident_byte();
      case ($urandom_range(0, 5))
         0: return 8'($urandom_range(8'h80, 8'hFF));
         1: return 8'($urandom_range(int'("0"), int'("9")));
         2: return $urandom_range(0, 1) ? CH_USCORE : CH_DOLLAR;
         3: return 8'($urandom_range(int'("A"), int'("Z")));
         default: return 8'($urandom_range(int'("a"), int'("z")));
      endcase
   endfunction

   // printable body byte that stays clear of the given delimiters
   function automatic logic [7:0] body_byte(logic [7:0] avoid1, logic [7:0] avoid2);
      logic [7:0] b;
      b = 8'($urandom_range(C_SPACE, C_IDMAX));
      if (b == avoid1 || b == avoid2 || b == CH_BSLASH) b = "q";
      return b;
   endfunction

   // one source fragment: mostly well-formed tokens, some noise
   function automatic void add_token();
      string      ops;
      string      openers;
      logic [7:0] q;
      int         n;
      ops     = "(){}[];,=:+-!&|?<>.*~%^/";
      openers = "=(,:!&|?{};[";
      case ($urandom_range(0, 11))
         0, 1: begin
            n = $urandom_range(1, 5);
            repeat (n) source_text.push_back(ident_byte());
         end
         2: begin
            n = $urandom_range(1, 3);
            repeat (n) begin
               case ($urandom_range(0, 4))
                  0: source_text.push_back(CH_SPACE);
                  1: source_text.push_back(CH_TAB);
                  2: source_text.push_back(CH_LF);
                  3: source_text.push_back(CH_CR);
                  default: source_text.push_back(8'($urandom_range(0, C_SPACE - 1)));
               endcase
            end
         end
         3, 4: source_text.push_back(ops[$urandom_range(0, ops.len() - 1)]);
         5: begin
            // string literal, escapes carry any byte
            q = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
            source_text.push_back(q);
            n = $urandom_range(0, 4);
            repeat (n) begin
               if ($urandom_range(0, 4) == 0) begin
                  source_text.push_back(CH_BSLASH);
                  source_text.push_back(8'($urandom_range(0, 255)));
               end else begin
                  source_text.push_back(body_byte(q, q));
               end
            end
            source_text.push_back(q);
         end
         6: begin
            // regex literal after an opener
            source_text.push_back(openers[$urandom_range(0, openers.len() - 1)]);
            source_text.push_back(CH_SLASH);
            n = $urandom_range(1, 3);
            repeat (n) begin
               if ($urandom_range(0, 3) == 0) begin
                  source_text.push_back(CH_BSLASH);
                  source_text.push_back($urandom_range(0, 1) ? CH_SLASH : body_byte(0, 0));
               end else begin
                  source_text.push_back(body_byte(CH_SLASH, CH_STAR));
               end
            end
            source_text.push_back(CH_SLASH);
            if ($urandom_range(0, 1)) source_text.push_back("g");
         end
         7: begin
            source_text.push_back(CH_SLASH);
            source_text.push_back(CH_STAR);
            n = $urandom_range(0, 4);
            repeat (n) source_text.push_back(body_byte(CH_SLASH, CH_SLASH));
            source_text.push_back(CH_STAR);
            source_text.push_back(CH_SLASH);
         end
         8: begin
            source_text.push_back(CH_SLASH);
            source_text.push_back(CH_SLASH);
            n = $urandom_range(0, 4);
            repeat (n) source_text.push_back(body_byte(CH_SLASH, CH_SLASH));
            source_text.push_back($urandom_range(0, 1) ? CH_LF : CH_CR);
         end
         9: begin
            n = $urandom_range(1, 2);
            repeat (n) source_text.push_back(8'($urandom_range(0, 255)));
         end
         default: begin
            // broken fragment: a lone delimiter
            case ($urandom_range(0, 3))
               0: source_text.push_back(CH_SLASH);
               1: source_text.push_back(CH_STAR);
               2: source_text.push_back($urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE);
               default: source_text.push_back(CH_BSLASH);
            endcase
         end
      endcase
   endfunction

   task automatic random_phase(input int count);
      int sent;
      sent = 0;
      while (sent < count) begin
         source_text.delete();
         add_token();
         foreach (source_text[i]) send_item(source_text[i], 1'b0);
         sent += source_text.size();
      end
   endtask

   // tail of the stream, sometimes left open, then end of input
   task automatic finish_stream();
      source_text.delete();
      case ($urandom_range(0, 3))
         1: begin
            source_text.push_back(CH_SLASH);
            source_text.push_back(CH_STAR);
            source_text.push_back("c");
         end
         2: begin
            source_text.push_back(CH_SQUOTE);
            source_text.push_back("s");
         end
         3: begin
            source_text.push_back("=");
            source_text.push_back(CH_SLASH);
            source_text.push_back("r");
         end
         default: ;
      endcase
      foreach (source_text[i]) send_item(source_text[i], 1'b0);
      send_item(8'($urandom_range(0, 255)), 1'b1);
      // the block ignores anything after the end
      repeat (2) send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      req_ch.valid <= 1'b0;
   endtask

   // stimulus and final verdict
   initial begin
      req_ch.valid              = 1'b0;
      req_ch.in_char            = 8'h00;
      req_ch.end_of_input       = 1'b0;
      csr_ch.valid              = 1'b0;
      csr_ch.keep_first_comment = 1'b0;
      keep_cfg          = 1'b0;
      lx_mode           = LEX_NEXT;
      win_a             = CH_LF;
      quote_ch          = 8'h00;
      keep_live         = 1'b0;
      slash_held        = 1'b0;
      regex_just_closed = 1'b0;
      stream_started    = 1'b0;
      stream_err        = ERR_NONE;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      write_keep(1'b0);
      write_keep(1'b1);
      foreach (DIRECTED[i])
         send_item(DIRECTED[i].ch, DIRECTED[i].eoi, DIRECTED[i].typed,
                   DIRECTED[i].n_want, DIRECTED[i].want);
      write_keep(1'b0);
      random_phase(RANDOM_ITEMS / 2);
      write_keep(1'b1);
      random_phase(RANDOM_ITEMS / 2);
      finish_stream();
      settle_block();

      if (!mismatch_seen) begin
         $display("javascript_minifier_stream verification clean");
      end else begin
         $display("javascript_minifier_stream verification failed");
      end
      $finish;
   end

   // result side ready, with random stalls per transfer
   initial begin
      int gap;
      bit quiet;
      int taken;
      rsp_ch.ready = 1'b0;
      quiet = 1'b0;
      taken = 0;
      wait (reset == 1'b0);
      forever begin
         gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
         if (gap != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid && rsp_ch.ready));
         taken++;
         if (taken % 16 == 0) quiet = ($urandom_range(0, 3) == 0);
      end
   end

   // compare each result transfer with the oldest expectation
   always @(posedge clock) begin
      min_out_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (minified_q.size() == 0) begin
            $error("unexpected result: out_char %0h char_valid %0b stream_done %0b",
                   rsp_ch.out_char, rsp_ch.char_valid, rsp_ch.stream_done);
            mismatch_seen = 1'b1;
         end else begin
            want = minified_q.pop_front();
            if (rsp_ch.char_valid !== want.char_valid) begin
               $error("char_valid: expected %0b, got %0b", want.char_valid, rsp_ch.char_valid);
               mismatch_seen = 1'b1;
            end
            if (want.char_valid && rsp_ch.out_char !== want.out_char) begin
               $error("out_char: expected %0h, got %0h", want.out_char, rsp_ch.out_char);
               mismatch_seen = 1'b1;
            end
            if (rsp_ch.last_of_run !== want.last_of_run) begin
               $error("last_of_run: expected %0b, got %0b", want.last_of_run,
                      rsp_ch.last_of_run);
               mismatch_seen = 1'b1;
            end
            if (rsp_ch.error_code !== want.error_code) begin
               $error("error_code: expected %0d, got %0d", want.error_code,
                      rsp_ch.error_code);
               mismatch_seen = 1'b1;
            end
            if (rsp_ch.stream_done !== want.stream_done) begin
               $error("stream_done: expected %0b, got %0b", want.stream_done,
                      rsp_ch.stream_done);
               mismatch_seen = 1'b1;
            end
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
         $display("javascript_minifier_stream verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
